FILE: sv/lstg_pkg.sv
// ---------------------------------------------------------------------------
// lstg_pkg: shared types and constants for the leg stride trajectory core
// Widths, register indexes, the CORDIC arctangent table and sequencer states.
// ---------------------------------------------------------------------------
package lstg_pkg;

  localparam int LEN_W    = 16;
  localparam int ANG_W    = 16;
  localparam int TIME_W   = 16;
  localparam int CORDIC_N = 24;
  localparam int CNT_W    = 5;
  localparam int CFG_W    = 16;
  localparam int IDX_W    = 3;

  localparam logic [IDX_W-1:0] REG_STEP_HEIGHT = 3'd0;
  localparam logic [IDX_W-1:0] REG_OFF_X       = 3'd1;
  localparam logic [IDX_W-1:0] REG_OFF_Y       = 3'd2;
  localparam logic [IDX_W-1:0] REG_OFF_Z       = 3'd3;
  localparam logic [IDX_W-1:0] REG_MOUNT       = 3'd4;
  localparam logic [IDX_W-1:0] REG_WS_END      = 3'd5;
  localparam logic [IDX_W-1:0] REG_MAX_STRIDE  = 3'd6;

  localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_PATH,
    ST_COR1,
    ST_ELL,
    ST_PT,
    ST_COR2,
    ST_ROT,
    ST_OUT
  } state_t;

  function automatic logic [31:0] atan_turn(input logic [CNT_W-1:0] i);
    logic [31:0] v;
    begin
      case (i)
        5'd0:  v = 32'd536870912;
        5'd1:  v = 32'd316933406;
        5'd2:  v = 32'd167458907;
        5'd3:  v = 32'd85004756;
        5'd4:  v = 32'd42667331;
        5'd5:  v = 32'd21354465;
        5'd6:  v = 32'd10679838;
        5'd7:  v = 32'd5340245;
        5'd8:  v = 32'd2670163;
        5'd9:  v = 32'd1335087;
        5'd10: v = 32'd667544;
        5'd11: v = 32'd333772;
        5'd12: v = 32'd166886;
        5'd13: v = 32'd83443;
        5'd14: v = 32'd41722;
        5'd15: v = 32'd20861;
        5'd16: v = 32'd10430;
        5'd17: v = 32'd5215;
        5'd18: v = 32'd2608;
        5'd19: v = 32'd1304;
        5'd20: v = 32'd652;
        5'd21: v = 32'd326;
        5'd22: v = 32'd163;
        5'd23: v = 32'd81;
        default: v = 32'd0;
      endcase
      return v;
    end
  endfunction

  function automatic logic signed [LEN_W-1:0] sat_len(input logic signed [39:0] v);
    logic signed [39:0] hi;
    logic signed [39:0] lo;
    begin
      hi = 40'sd32767;
      lo = -40'sd32768;
      if (v > hi) return 16'sh7fff;
      else if (v < lo) return 16'sh8000;
      else return v[LEN_W-1:0];
    end
  endfunction

endpackage

FILE: sv/lstg_div.sv
// ---------------------------------------------------------------------------
// lstg_div: restoring divider, one quotient bit per cycle
// Unsigned 48 by 16 divide, used for both the stance advance and the angle.
// ---------------------------------------------------------------------------
module lstg_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [47:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [47:0] quotient
);

  logic [47:0] q_r, q_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [15:0] dvs_r, dvs_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [16:0] trial;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r[15:0], q_r[47]};
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = 6'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = trial - {1'b0, dvs_r};
        q_nxt   = {q_r[46:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[46:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd47) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = busy_r && (cnt_r == 6'd47);
  assign quotient = {q_r[46:0], (trial >= {1'b0, dvs_r})};

endmodule

FILE: sv/lstg_cordic.sv
// ---------------------------------------------------------------------------
// lstg_cordic: iterative CORDIC rotator, one micro-rotation per cycle
// Returns Q30 sine and cosine of a 32-bit turn angle after 24 steps.
// ---------------------------------------------------------------------------
module lstg_cordic (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [31:0]         angle,
  output logic                done,
  output logic signed [33:0]  sin_q30,
  output logic signed [33:0]  cos_q30
);

  logic signed [33:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [33:0] z_r, z_nxt;
  logic               flip_r, flip_nxt;
  logic [lstg_pkg::CNT_W-1:0] i_r, i_nxt;
  logic               busy_r, busy_nxt;
  logic [31:0]        shifted, rot;
  logic signed [33:0] dx, dy, at;

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    flip_nxt = flip_r;
    i_nxt    = i_r;
    busy_nxt = busy_r;
    shifted  = angle + 32'h4000_0000;
    rot      = shifted[31] ? (angle ^ 32'h8000_0000) : angle;
    dx       = y_r >>> i_r;
    dy       = x_r >>> i_r;
    at       = $signed({2'b00, lstg_pkg::atan_turn(i_r)});
    if (start) begin
      flip_nxt = shifted[31];
      z_nxt    = $signed({{2{rot[31]}}, rot});
      x_nxt    = lstg_pkg::CORDIC_X0;
      y_nxt    = '0;
      i_nxt    = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!z_r[33]) begin
        x_nxt = x_r - dx;
        y_nxt = y_r + dy;
        z_nxt = z_r - at;
      end else begin
        x_nxt = x_r + dx;
        y_nxt = y_r - dy;
        z_nxt = z_r + at;
      end
      i_nxt = i_r + 5'd1;
      if (i_r == 5'(lstg_pkg::CORDIC_N - 1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      i_r    <= '0;
    end else begin
      busy_r <= busy_nxt;
      i_r    <= i_nxt;
    end
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    flip_r <= flip_nxt;
  end

  // done is registered from the last step, so it rises in the cycle after it, results held in x/y
  logic fin_r;
  always_ff @(posedge clk) begin
    if (!rst_n) fin_r <= 1'b0;
    else fin_r <= busy_r && (i_r == 5'(lstg_pkg::CORDIC_N - 1));
  end

  assign done    = fin_r;
  assign cos_q30 = flip_r ? -x_r : x_r;
  assign sin_q30 = flip_r ? -y_r : y_r;

endmodule

FILE: sv/leg_stride_trajectory_generator_core.sv
// ---------------------------------------------------------------------------
// leg_stride_trajectory_generator_core: one leg trajectory tick per request
// Per request: a registered divider launch after acceptance, the divider, then
// one or two 24-step CORDIC passes (ellipse for transfer only, then mount
// rotation), each done registered, plus sequencing states (PATH, ELL, PT, ROT).
// No new request is taken while one is in flight; in_tready stays low until the
// result is taken.
// Reset (synchronous, rst_n low) clears config, state, start and last points, sets first tick.
// ---------------------------------------------------------------------------
module leg_stride_trajectory_generator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // phase_time[15:0], phase_period[31:16], stance_stride[47:32],
  // transfer_stride[63:48], heading_angle[79:64]
  input  logic [79:0] in_tdata,
  // phase_kind[0], phase_changed[1]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // leg_x[15:0], leg_y[31:16], leg_z[47:32]
  output logic [47:0] out_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  typedef logic signed [15:0] len_t;

  // configuration
  logic [14:0] step_h_r, max_str_r;
  len_t off_x_r, off_y_r, off_z_r, ws_end_r;
  logic [15:0] mount_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_h_r <= '0; max_str_r <= '0;
      off_x_r <= '0; off_y_r <= '0; off_z_r <= '0; ws_end_r <= '0; mount_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        lstg_pkg::REG_STEP_HEIGHT: step_h_r  <= cfg_wdata[14:0];
        lstg_pkg::REG_OFF_X:       off_x_r   <= cfg_wdata;
        lstg_pkg::REG_OFF_Y:       off_y_r   <= cfg_wdata;
        lstg_pkg::REG_OFF_Z:       off_z_r   <= cfg_wdata;
        lstg_pkg::REG_MOUNT:       mount_r   <= cfg_wdata;
        lstg_pkg::REG_WS_END:      ws_end_r  <= cfg_wdata;
        lstg_pkg::REG_MAX_STRIDE:  max_str_r <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  // latched request
  logic [15:0] t_r, per_r, head_r;
  len_t ls_r, lt_r;
  logic kind_r;

  // state
  lstg_pkg::state_t st_r, st_nxt;
  logic first_r;
  len_t ss0_r, ss1_r, ss2_r, ts0_r, ts1_r, ts2_r, lp0_r, lp1_r, lp2_r;
  logic        neg_r;
  logic [47:0] q_r;
  logic signed [33:0] s_r, c_r;
  len_t ox_r, oy_r, oz_r;
  // divider launch, registered from acceptance so it starts in the cycle after and sees the latched request
  logic        div_go_r;

  // divider
  logic        div_start, div_done;
  logic [47:0] div_dvd, div_q;
  logic [15:0] per_eff;
  logic [31:0] prod_abs;
  logic signed [31:0] prod;

  assign per_eff = (per_r == 16'd0) ? 16'd1 : per_r;
  assign prod    = ls_r * $signed({1'b0, t_r});
  assign prod_abs = prod[31] ? 32'(-prod) : 32'(prod);
  assign div_dvd = kind_r ? {1'b0, t_r, 31'd0} : {16'd0, prod_abs};

  lstg_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dvd),
    .divisor(per_eff), .done(div_done), .quotient(div_q)
  );

  // CORDIC
  logic        cor_start, cor_done;
  logic [31:0] cor_ang;
  logic signed [33:0] cor_s, cor_c;

  assign cor_ang = (st_r == lstg_pkg::ST_PATH) ? q_r[31:0]
                 : ({mount_r, 16'd0} + {head_r, 16'd0});

  lstg_cordic u_cor (
    .clk(clk), .rst_n(rst_n), .start(cor_start), .angle(cor_ang),
    .done(cor_done), .sin_q30(cor_s), .cos_q30(cor_c)
  );

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      lstg_pkg::ST_IDLE: if (in_tvalid) st_nxt = lstg_pkg::ST_DIV;
      lstg_pkg::ST_DIV:  if (div_done) st_nxt = lstg_pkg::ST_PATH;
      lstg_pkg::ST_PATH: st_nxt = kind_r ? lstg_pkg::ST_COR1 : lstg_pkg::ST_PT;
      lstg_pkg::ST_COR1: if (cor_done) st_nxt = lstg_pkg::ST_ELL;
      lstg_pkg::ST_ELL:  st_nxt = lstg_pkg::ST_PT;
      lstg_pkg::ST_PT:   st_nxt = lstg_pkg::ST_COR2;
      lstg_pkg::ST_COR2: if (cor_done) st_nxt = lstg_pkg::ST_ROT;
      lstg_pkg::ST_ROT:  st_nxt = lstg_pkg::ST_OUT;
      lstg_pkg::ST_OUT:  if (out_tready) st_nxt = lstg_pkg::ST_IDLE;
      default:           st_nxt = lstg_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_tready  = (st_r == lstg_pkg::ST_IDLE);
    out_tvalid = (st_r == lstg_pkg::ST_OUT);
    div_start  = div_go_r;
    cor_start  = ((st_r == lstg_pkg::ST_PATH) && kind_r) || (st_r == lstg_pkg::ST_PT);
  end

  // datapath: ellipse products read in ST_ELL, rotation products in ST_ROT
  len_t half_in;
  logic signed [39:0] base, adv;
  logic signed [63:0] ex, ez, rxa, rya;

  assign half_in = len_t'($signed(in_tdata[63:48]) >>> 1);
  assign base    = 40'(off_y_r) - 40'(ws_end_r) - 40'($signed({1'b0, max_str_r}));
  assign adv     = neg_r ? -$signed({8'd0, q_r[31:0]}) : $signed({8'd0, q_r[31:0]});
  assign ex = (64'(lt_r) * 64'(c_r) + 64'sd1073741824) >>> 31;
  assign ez = (64'($signed({1'b0, step_h_r})) * 64'(s_r) + 64'sd536870912) >>> 30;
  assign rxa = (64'(lp0_r) * 64'(cor_c) - 64'(lp1_r) * 64'(cor_s) + 64'sd536870912) >>> 30;
  assign rya = (64'(lp0_r) * 64'(cor_s) + 64'(lp1_r) * 64'(cor_c) + 64'sd536870912) >>> 30;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= lstg_pkg::ST_IDLE;
      first_r <= 1'b1;
      div_go_r <= 1'b0;
      ss0_r <= '0; ss1_r <= '0; ss2_r <= '0;
      ts0_r <= '0; ts1_r <= '0; ts2_r <= '0;
      lp0_r <= '0; lp1_r <= '0; lp2_r <= '0;
    end else begin
      st_r <= st_nxt;
      div_go_r <= (st_r == lstg_pkg::ST_IDLE) && in_tvalid;
      case (st_r)
        lstg_pkg::ST_IDLE: if (in_tvalid) begin
          // start points update at acceptance
          if (first_r) begin
            first_r <= 1'b0;
            ss0_r <= lstg_pkg::sat_len(base);
            ts0_r <= lstg_pkg::sat_len(base + 40'(half_in));
            ss1_r <= '0; ss2_r <= '0; ts1_r <= '0; ts2_r <= '0;
          end else if (in_tuser[1]) begin
            ss0_r <= lp0_r; ss1_r <= lp1_r; ss2_r <= lp2_r;
            ts0_r <= lstg_pkg::sat_len(40'(lp0_r) - 40'(half_in));
            ts1_r <= lp1_r; ts2_r <= lp2_r;
          end
        end
        lstg_pkg::ST_PATH: if (!kind_r) begin
          lp0_r <= lstg_pkg::sat_len(40'(ss0_r) + adv);
          lp1_r <= ss1_r; lp2_r <= ss2_r;
        end
        lstg_pkg::ST_ELL: begin
          lp0_r <= lstg_pkg::sat_len(40'(ts0_r) + 40'(ex));
          lp1_r <= ts1_r;
          lp2_r <= lstg_pkg::sat_len(40'(ts2_r) + 40'(ez));
        end
        lstg_pkg::ST_ROT: begin
          ox_r <= lstg_pkg::sat_len(40'(off_x_r) + 40'(rxa));
          oy_r <= lstg_pkg::sat_len(40'(off_y_r) + 40'(rya));
          oz_r <= lstg_pkg::sat_len(40'(off_z_r) + 40'(lp2_r));
        end
        default: ;
      endcase
    end
    if (in_tvalid && in_tready) begin
      t_r <= in_tdata[15:0]; per_r <= in_tdata[31:16];
      ls_r <= in_tdata[47:32]; lt_r <= in_tdata[63:48];
      head_r <= in_tdata[79:64]; kind_r <= in_tuser[0];
    end
    if (st_r == lstg_pkg::ST_DIV) neg_r <= prod[31];
    if (div_done) q_r <= div_q;
    if (st_r == lstg_pkg::ST_COR1 && cor_done) begin
      s_r <= cor_s; c_r <= cor_c;
    end
  end

  assign out_tdata = {oz_r, oy_r, ox_r};

endmodule

FILE: sim/lstg_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lstg_checker: trajectory predictor and result scoreboard
// Watches both stream channels and the register port, computes the leg-frame
// point for every accepted request and compares it with the block's result.
// ---------------------------------------------------------------------------
module lstg_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [79:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  output int          fail_count,
  output int          pending,
  output int          results_seen
);

  logic [15:0] r_height, r_ox, r_oy, r_oz, r_mount, r_ws, r_maxs;
  bit          first_pt;
  longint      st_start[3], tr_start[3], prev_pt[3];
  logic [47:0] point_q[$];

  function automatic longint clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  task automatic cordic(input logic [31:0] a, output longint s, output longint c);
    bit          flip;
    logic [31:0] r;
    longint      z, x, y, dx, dy;
    int          i;
    flip = ((a + 32'h4000_0000) & 32'h8000_0000) != 0;
    r = flip ? (a ^ 32'h8000_0000) : a;
    z = longint'($signed(r));
    x = 652032874;
    y = 0;
    for (i = 0; i < lstg_pkg::CORDIC_N; i++) begin
      dx = fshr(y, i);
      dy = fshr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(lstg_pkg::atan_turn(i[4:0]));
      end else begin
        x += dx; y -= dy; z += longint'(lstg_pkg::atan_turn(i[4:0]));
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  task automatic predict_point(input logic [79:0] d, input logic [1:0] u);
    longint t, per, ls, lt, half, p[3], s, c, rx, ry, base, adv, h;
    logic [31:0] th;
    logic [63:0] num;
    int i;
    t = d[15:0];
    per = d[31:16];
    ls = longint'($signed(d[47:32]));
    lt = longint'($signed(d[63:48]));
    half = fshr(lt, 1);
    if (per == 0) per = 1;
    if (u[1]) begin
      for (i = 0; i < 3; i++) begin
        st_start[i] = prev_pt[i];
        tr_start[i] = prev_pt[i];
      end
      tr_start[0] = clamp16(prev_pt[0] - half);
    end
    if (first_pt) begin
      base = longint'($signed(r_oy)) - longint'($signed(r_ws)) - longint'(r_maxs[14:0]);
      first_pt = 0;
      st_start[0] = clamp16(base);
      tr_start[0] = clamp16(base + half);
      for (i = 1; i < 3; i++) begin
        st_start[i] = 0;
        tr_start[i] = 0;
      end
    end
    if (!u[0]) begin
      adv = (ls * t) / per;
      p[0] = st_start[0] + adv;
      p[1] = st_start[1];
      p[2] = st_start[2];
    end else begin
      num = 64'(t) << 31;
      th = 32'(num / 64'(per));
      h = r_height[14:0];
      cordic(th, s, c);
      p[0] = tr_start[0] + fshr(lt * c + (64'sd1 <<< 30), 31);
      p[1] = tr_start[1];
      p[2] = tr_start[2] + fshr(h * s + (64'sd1 <<< 29), 30);
    end
    for (i = 0; i < 3; i++) prev_pt[i] = clamp16(p[i]);
    cordic({r_mount, 16'h0} + {d[79:64], 16'h0}, s, c);
    rx = fshr(prev_pt[0] * c - prev_pt[1] * s + (64'sd1 <<< 29), 30);
    ry = fshr(prev_pt[0] * s + prev_pt[1] * c + (64'sd1 <<< 29), 30);
    point_q.push_back({16'(clamp16(longint'($signed(r_oz)) + prev_pt[2])),
                       16'(clamp16(longint'($signed(r_oy)) + ry)),
                       16'(clamp16(longint'($signed(r_ox)) + rx))});
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      r_height <= '0; r_ox <= '0; r_oy <= '0; r_oz <= '0;
      r_mount <= '0; r_ws <= '0; r_maxs <= '0;
      first_pt = 1;
      for (int i = 0; i < 3; i++) begin
        st_start[i] = 0; tr_start[i] = 0; prev_pt[i] = 0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          lstg_pkg::REG_STEP_HEIGHT: r_height <= cfg_wdata;
          lstg_pkg::REG_OFF_X:       r_ox <= cfg_wdata;
          lstg_pkg::REG_OFF_Y:       r_oy <= cfg_wdata;
          lstg_pkg::REG_OFF_Z:       r_oz <= cfg_wdata;
          lstg_pkg::REG_MOUNT:       r_mount <= cfg_wdata;
          lstg_pkg::REG_WS_END:      r_ws <= cfg_wdata;
          lstg_pkg::REG_MAX_STRIDE:  r_maxs <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) predict_point(in_tdata, in_tuser);
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (point_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result %h", out_tdata);
        end else begin
          logic [47:0] exp_pt;
          exp_pt = point_q.pop_front();
          if (exp_pt !== out_tdata) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch x/y/z exp %h %h %h got %h %h %h",
                       exp_pt[15:0], exp_pt[31:16], exp_pt[47:32],
                       out_tdata[15:0], out_tdata[31:16], out_tdata[47:32]);
          end
        end
      end
    end
    pending = point_q.size();
  end

  initial begin
    fail_count = 0;
    pending = 0;
    results_seen = 0;
  end

endmodule

FILE: sim/leg_stride_trajectory_generator_core_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// leg_stride_trajectory_generator_core_test: stimulus and verdict
// Directed ticks, then random stride cycles under several register settings
// and three idling profiles; the checker module predicts and compares.
// ---------------------------------------------------------------------------
module leg_stride_trajectory_generator_core_test;

  logic        clk, rst_n;
  logic        in_tvalid, in_tready;
  logic [79:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid, out_tready;
  logic [47:0] out_tdata;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_wdata;
  int          fail_count, pending, results_seen;
  int          send_idle_pct, recv_idle_pct;
  int          cycle_cnt;
  int          requests_sent;

  leg_stride_trajectory_generator_core u_top (.*);

  lstg_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // watchdog: allows ~1000 requests with stalls many times over
  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk);
      cycle_cnt++;
      if (cycle_cnt > 2_000_000) begin
        $display("[leg_stride_trajectory_generator_core] ERROR");
        $finish;
      end
    end
  end

  // receiver stalls at random
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 0;
    else out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // write enable stays up across a burst; set_regs drops it at the end
  task automatic cfg_write(input logic [2:0] idx, input logic [15:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
  endtask

  // one request; tvalid stays up back to back when no idle cycle is drawn
  task automatic send_tick(input logic [79:0] d, input logic [1:0] u);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1; in_tdata <= d; in_tuser <= u;
    do @(posedge clk); while (!in_tready);
    requests_sent++;
  endtask

  task automatic drain;
    in_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic logic [79:0] pack_tick(logic [15:0] t, logic [15:0] per,
                                            logic [15:0] ls, logic [15:0] lt,
                                            logic [15:0] hd);
    return {hd, lt, ls, per, t};
  endfunction

  task automatic set_regs(input int mode);
    logic [15:0] v[7];
    for (int i = 0; i < 7; i++) begin
      case (mode)
        0: v[i] = 16'h0000;
        1: v[i] = (i == 0 || i == 6) ? 16'h7fff : 16'h8000;
        2: v[i] = (i == 0 || i == 6) ? 16'h7fff : 16'h7fff;
        default: v[i] = (i == 0 || i == 6) ? 16'($urandom_range(4000))
                                           : 16'($urandom_range(8000)) - 16'd4000;
      endcase
      cfg_write(i[2:0], v[i]);
    end
    cfg_we <= 0;
  endtask

  // a realistic stride: stance then transfer, time zero first, then mostly drawn within the period
  task automatic stride_run;
    logic [15:0] per, ls, lt, hd, t;
    int n;
    per = 16'($urandom_range(1, 200));
    if ($urandom_range(9) == 0) per = 16'($urandom);
    ls = 16'($urandom); lt = 16'($urandom); hd = 16'($urandom);
    for (int ph = 0; ph < 2; ph++) begin
      n = $urandom_range(1, 5);
      for (int k = 0; k < n; k++) begin
        t = (k == 0) ? 16'd0 : 16'($urandom_range(per));
        if ($urandom_range(19) == 0) t = 16'($urandom);
        send_tick(pack_tick(t, per, ls, lt, hd), {k == 0, ph[0]});
      end
    end
  endtask

  initial begin
    rst_n = 0; in_tvalid = 0; in_tdata = '0; in_tuser = '0;
    cfg_we = 0; cfg_index = '0; cfg_wdata = '0;
    send_idle_pct = 24; recv_idle_pct = 59; requests_sent = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: first tick with random registers, then extremes
    set_regs(3);
    send_tick(pack_tick(16'd0, 16'd10, 16'd100, 16'd200, 16'd0), 2'b00);
    send_tick(pack_tick(16'd5, 16'd10, 16'd100, 16'd200, 16'd0), 2'b00);
    send_tick(pack_tick(16'd0, 16'd10, 16'd100, 16'd200, 16'h4000), 2'b11);
    send_tick(pack_tick(16'd5, 16'd10, 16'd100, 16'h8000, 16'h8000), 2'b01);
    send_tick(pack_tick(16'd10, 16'd10, 16'h7fff, 16'h7fff, 16'h7fff), 2'b01);
    send_tick(pack_tick(16'd0, 16'd0, 16'h8000, 16'h8000, 16'hc000), 2'b10);
    send_tick(pack_tick(16'hffff, 16'd0, 16'h7fff, 16'h7fff, 16'hffff), 2'b00);
    send_tick(pack_tick(16'hffff, 16'd1, 16'h8000, 16'h7fff, 16'h0001), 2'b01);
    send_tick(pack_tick(16'hffff, 16'hffff, 16'h8000, 16'h8001, 16'h2000), 2'b11);
    send_tick(pack_tick(16'd3, 16'hffff, 16'hffff, 16'hffff, 16'h6000), 2'b01);
    send_tick(pack_tick(16'd40, 16'd3, 16'h7fff, 16'h8000, 16'ha000), 2'b00);
    drain;
    set_regs(1);
    send_tick(pack_tick(16'd1, 16'd2, 16'h7fff, 16'h8000, 16'h8000), 2'b11);
    send_tick(pack_tick(16'd1, 16'd2, 16'h8000, 16'h7fff, 16'h7fff), 2'b01);
    send_tick(pack_tick(16'd2, 16'd3, 16'h8000, 16'h7fff, 16'h0000), 2'b10);
    drain;
    set_regs(2);
    send_tick(pack_tick(16'd7, 16'd9, 16'h7fff, 16'h7fff, 16'h4000), 2'b11);
    send_tick(pack_tick(16'd9, 16'd9, 16'h8000, 16'h8000, 16'hc000), 2'b00);
    drain;

    // random phases, one idling profile each, registers changed between
    for (int prof = 0; prof < 3; prof++) begin
      send_idle_pct = (prof == 0) ? 24 : (prof == 1) ? 59 : 0;
      recv_idle_pct = (prof == 0) ? 59 : (prof == 1) ? 24 : 0;
      for (int blk = 0; blk < 4; blk++) begin
        set_regs(blk == 0 ? prof : 3);
        for (int r = 0; r < 16; r++) begin
          if ($urandom_range(4) == 0)
            send_tick({$urandom, $urandom, 16'($urandom)}, 2'($urandom));
          else
            stride_run;
        end
        drain;
      end
    end

    drain;
    $display("covered %0d requests, %0d results, three idling profiles, register extremes",
             requests_sent, results_seen);
    if (fail_count == 0) begin
      $display("[leg_stride_trajectory_generator_core] OK");
    end else begin
      $display("[leg_stride_trajectory_generator_core] ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/lstg_pkg.sv
sv/lstg_div.sv
sv/lstg_cordic.sv
sv/leg_stride_trajectory_generator_core.sv
sim/lstg_checker.sv
sim/leg_stride_trajectory_generator_core_test.sv
